[hdl/zvt_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zvt_pkg - shared definitions of the zone valve timer
// Field widths, command codes and the structs that pass between the zone
// slices and the top level.
// ---------------------------------------------------------------------------
package zvt_pkg;

   localparam int CMD_W   = 2;
   localparam int ZONE_W  = 3;
   localparam int SECS_W  = 16;
   localparam int LEVEL_W = 11;
   localparam int CNT_W   = 26;
   localparam int MASK_W  = 4;

   localparam int ZONES_DEFAULT = 4;
   localparam int TICKS_DEFAULT = 1000;

   localparam logic [CNT_W-1:0]  CNT_MAX       = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0]  TIMEOUT_RESET = CNT_W'(600000);
   localparam logic [SECS_W-1:0] SECS_MAX      = {SECS_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_OPEN  = 2'd1,
      CMD_CLOSE = 2'd2,
      CMD_CHECK = 2'd3
   } cmd_type;

   // Broadcast to every zone slice for the transaction being processed
   typedef struct packed {
      logic             fire;
      cmd_type          cmd;
      logic             empty;
      logic [CNT_W-1:0] duration;
      logic [CNT_W-1:0] timeout;
   } zone_ctrl_type;

   typedef struct packed {
      logic             open;
      logic [CNT_W-1:0] elapsed;
      logic [CNT_W-1:0] duration;
   } zone_state_type;

   typedef struct packed {
      logic empty;
      logic timeout;
      logic done;
   } zone_close_type;

endpackage

[hdl/zvt_zone.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zvt_zone - state slice of one irrigation zone
// Holds the open flag, elapsed and duration counters of one zone and
// applies tick, open, close and safety check commands to them.
// ---------------------------------------------------------------------------
module zvt_zone (
   input  logic                   clock,
   input  logic                   reset,
   input  zvt_pkg::zone_ctrl_type ctrl,
   input  logic                   hit,
   output zvt_pkg::zone_state_type next_state,
   output zvt_pkg::zone_close_type closed
);
   import zvt_pkg::*;

   zone_state_type state_ff;
   zone_state_type state_in;
   zone_close_type close_in;

   always_comb begin
      state_in = state_ff;
      close_in = '0;
      case (ctrl.cmd)
         CMD_TICK: begin
            if (state_ff.open && state_ff.elapsed != CNT_MAX) begin
               state_in.elapsed = state_ff.elapsed + CNT_W'(1);
            end
         end
         CMD_OPEN: begin
            if (hit) begin
               state_in.open     = 1'b1;
               state_in.elapsed  = '0;
               state_in.duration = ctrl.duration;
            end
         end
         CMD_CLOSE: begin
            if (hit) begin
               state_in = '0;
            end
         end
         CMD_CHECK: begin
            // empty tank wins, then the hard limit, then the run duration
            if (state_ff.open) begin
               if (ctrl.empty) begin
                  close_in.empty = 1'b1;
               end else if (state_ff.elapsed >= ctrl.timeout) begin
                  close_in.timeout = 1'b1;
               end else if (state_ff.elapsed >= state_ff.duration) begin
                  close_in.done = 1'b1;
               end
               if (close_in.empty || close_in.timeout || close_in.done) begin
                  state_in = '0;
               end
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (ctrl.fire) begin
         state_ff <= state_in;
      end
   end

   assign next_state = state_in;
   assign closed     = close_in;

endmodule

[hdl/zvt_remain.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zvt_remain - whole seconds left for one zone
// Divides the remaining ticks by the tick rate with a reciprocal multiply
// and saturates the quotient to the field width.
// ---------------------------------------------------------------------------
module zvt_remain #(
   parameter int TICKS_PER_SECOND = zvt_pkg::TICKS_DEFAULT
) (
   input  logic                         open,
   input  logic [zvt_pkg::CNT_W-1:0]    elapsed,
   input  logic [zvt_pkg::CNT_W-1:0]    duration,
   output logic [zvt_pkg::SECS_W-1:0]   seconds_left
);
   import zvt_pkg::*;

   // Shift chosen so the rounded-up reciprocal is exact over all counts
   localparam int K   = CNT_W + $clog2(TICKS_PER_SECOND);
   localparam int P_W = K + CNT_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << K) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
   localparam logic [P_W-1:0] RECIP = P_W'(RECIP_FULL);

   logic [CNT_W-1:0] diff;
   logic [P_W-1:0]   prod;
   logic [CNT_W-1:0] quot;

   assign diff = duration - elapsed;
   assign prod = P_W'(diff) * RECIP;
   assign quot = prod[P_W-1:K];

   always_comb begin
      if (!open || elapsed >= duration) begin
         seconds_left = '0;
      end else if (quot > CNT_W'(SECS_MAX)) begin
         seconds_left = SECS_MAX;
      end else begin
         seconds_left = quot[SECS_W-1:0];
      end
   end

endmodule

[hdl/zone_valve_timer_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zone_valve_timer_top - multi-zone irrigation valve timer
// Opens, closes and times out zone valves from a stream of commands.
// ---------------------------------------------------------------------------
// Usage:
//  - The req stream carries one command per transaction: tuser holds the
//    command (tick, open, close, safety check), tdata the zone number, the
//    run duration in seconds and the tank level.
//  - The rsp stream returns exactly one transaction per command: relay lines
//    (active low), open mask, the zones closed by that command split by
//    reason, and the open flag and whole seconds left for the named zone.
//  - The csr port writes the hard timeout in ms; write it only while idle.
//  - An accepted req goes into the input register (duration multiply done
//    on the way in), then through zone update and remaining-time divide
//    into the result register, which drives rsp valid.
//  - Throughput is one transaction per cycle while rsp is not stalled; the
//    input register and result register form a two-stage pipeline, so a
//    new command enters an empty input register while a result waits.
//  - When rsp is stalled the result register holds, the input register
//    fills, and req_tready then drops until rsp_tready returns.
//  - Synchronous reset closes every zone, clears all counters, empties the
//    pipeline and loads the timeout with 600000 ms.
// ---------------------------------------------------------------------------
module zone_valve_timer_top #(
   parameter int ZONES            = zvt_pkg::ZONES_DEFAULT,
   parameter int TICKS_PER_SECOND = zvt_pkg::TICKS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata: zone[2:0], seconds[18:3], tank_level[29:19], zero[31:30]
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,
   // req_tuser: cmd[1:0]
   input  logic [zvt_pkg::CMD_W-1:0] req_tuser,
   // rsp_tdata: relay_drive[3:0], open_mask[7:4], closed_empty[11:8],
   // closed_timeout[15:12], closed_done[19:16], zone_open[20],
   // seconds_left[36:21], zero[39:37]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [39:0]               rsp_tdata,
   // timeout_ms register
   input  logic                      csr_wr_en,
   input  logic [zvt_pkg::CNT_W-1:0] csr_wr_data
);
   import zvt_pkg::*;

   localparam int TPS_W    = $clog2(TICKS_PER_SECOND + 1);
   localparam int PROD_RAW = SECS_W + TPS_W;
   localparam int PROD_W   = (PROD_RAW > CNT_W) ? PROD_RAW : CNT_W + 1;

   // ---------------- request unpack and duration scaling ----------------
   logic [ZONE_W-1:0]  in_zone;
   logic [SECS_W-1:0]  in_seconds;
   logic [LEVEL_W-1:0] in_level;
   logic [PROD_W-1:0]  in_product;
   logic [CNT_W-1:0]   in_duration;

   assign in_zone    = req_tdata[ZONE_W-1:0];
   assign in_seconds = req_tdata[ZONE_W +: SECS_W];
   assign in_level   = req_tdata[ZONE_W+SECS_W +: LEVEL_W];

   // Scale seconds to ticks here so the update stage carries no multiplier
   assign in_product  = PROD_W'(in_seconds) * PROD_W'(TICKS_PER_SECOND);
   assign in_duration = (in_product > PROD_W'(CNT_MAX)) ? CNT_MAX
                                                        : in_product[CNT_W-1:0];

   // ---------------- pipeline control ----------------
   logic req_valid_ff, req_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic fire;

   // The update stage moves whenever the result register is free or drains
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = req_valid_ff && advance;
   assign req_tready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tvalid && req_tready) begin
         req_valid_in = 1'b1;
      end else if (fire) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- input register ----------------
   cmd_type          req_cmd_ff;
   logic [ZONE_W-1:0] req_zone_ff;
   logic [CNT_W-1:0] req_duration_ff;
   logic             req_empty_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_cmd_ff      <= cmd_type'(req_tuser);
         req_zone_ff     <= in_zone;
         req_duration_ff <= in_duration;
         // Empty when the signed level is zero or negative
         req_empty_ff    <= in_level[LEVEL_W-1] || (in_level == '0);
      end
   end

   // ---------------- timeout register ----------------
   logic [CNT_W-1:0] timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // ---------------- zone slices ----------------
   zone_ctrl_type  ctrl;
   zone_state_type zone_next [ZONES];
   zone_close_type zone_closed [ZONES];
   logic [ZONES-1:0] hit;

   assign ctrl.fire     = fire;
   assign ctrl.cmd      = req_cmd_ff;
   assign ctrl.empty    = req_empty_ff;
   assign ctrl.duration = req_duration_ff;
   assign ctrl.timeout  = timeout_ff;

   for (genvar g = 0; g < ZONES; g++) begin : g_zone
      // Zone numbers count from one; zero and out-of-range hit nothing
      assign hit[g] = (int'(req_zone_ff) == g + 1);

      zvt_zone u_zone (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .hit        (hit[g]),
         .next_state (zone_next[g]),
         .closed     (zone_closed[g])
      );
   end

   // ---------------- result assembly ----------------
   logic [MASK_W-1:0] open_mask;
   logic [MASK_W-1:0] closed_empty;
   logic [MASK_W-1:0] closed_timeout;
   logic [MASK_W-1:0] closed_done;

   for (genvar m = 0; m < MASK_W; m++) begin : g_mask
      if (m < ZONES) begin : g_used
         assign open_mask[m]      = zone_next[m].open;
         assign closed_empty[m]   = zone_closed[m].empty;
         assign closed_timeout[m] = zone_closed[m].timeout;
         assign closed_done[m]    = zone_closed[m].done;
      end else begin : g_unused
         assign open_mask[m]      = 1'b0;
         assign closed_empty[m]   = 1'b0;
         assign closed_timeout[m] = 1'b0;
         assign closed_done[m]    = 1'b0;
      end
   end

   // Pick the named zone's post-update state; no hit leaves it all zero
   zone_state_type sel_state;

   always_comb begin
      sel_state = '0;
      for (int z = 0; z < ZONES; z++) begin
         if (hit[z]) begin
            sel_state = zone_next[z];
         end
      end
   end

   logic [SECS_W-1:0] sel_seconds_left;

   zvt_remain #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_remain (
      .open         (sel_state.open),
      .elapsed      (sel_state.elapsed),
      .duration     (sel_state.duration),
      .seconds_left (sel_seconds_left)
   );

   // ---------------- result register ----------------
   logic [39:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= {3'b000,
                         sel_seconds_left,
                         sel_state.open,
                         closed_done,
                         closed_timeout,
                         closed_empty,
                         open_mask,
                         ~open_mask};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
